// ----- rtl/core/attribute_screen_cell_renderer_macros.svh -----
// Assertion macros shared by the renderer RTL.
// Depends on the including module having aclk and aresetn in scope.
`ifndef ATTRIBUTE_SCREEN_CELL_RENDERER_MACROS_SVH
`define ATTRIBUTE_SCREEN_CELL_RENDERER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed in cell renderer");

// Next-cycle implication, disabled while reset is held.
`define ASC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed in cell renderer");

`endif

// ----- rtl/core/asc_pkg.sv -----
// Shared types, constants and the palette table of the attribute cell renderer.
// No dependencies.
package asc_pkg;

    localparam int SCREEN_COLS = 256;
    localparam int SCREEN_ROWS = 192;
    localparam int PIX_BYTES   = SCREEN_COLS * SCREEN_ROWS / 8;
    localparam int ATTR_BYTES  = (SCREEN_COLS / 8) * (SCREEN_ROWS / 8);
    localparam int MEM_BYTES   = PIX_BYTES + ATTR_BYTES;
    localparam int ADDR_W      = $clog2(MEM_BYTES);
    localparam int QUEUE_DEPTH = 2;

    // Request codes
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_RENDER = 1'b1;

    // Attribute byte layout
    localparam logic [7:0] ATTR_INK_MASK    = 8'b0000_0111;
    localparam logic [7:0] ATTR_PAPER_MASK  = 8'b0011_1000;
    localparam logic [7:0] ATTR_BRIGHT_MASK = 8'b0100_0000;
    localparam logic [7:0] ATTR_FLASH_MASK  = 8'b1000_0000;

    // One render request after the memory reads
    typedef struct packed {
        logic [7:0] pix;
        logic [7:0] attr;
        logic [4:0] col;
        logic       phase;
    } asc_cell_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } asc_rgb_t;

    function automatic asc_rgb_t asc_palette(input logic [4:0] idx);
        asc_rgb_t c;
        case (idx)
            5'd0:  c = '{8'd0,   8'd0,   8'd0};
            5'd1:  c = '{8'd0,   8'd0,   8'd192};
            5'd2:  c = '{8'd192, 8'd0,   8'd0};
            5'd3:  c = '{8'd192, 8'd0,   8'd192};
            5'd4:  c = '{8'd0,   8'd192, 8'd0};
            5'd5:  c = '{8'd0,   8'd192, 8'd192};
            5'd6:  c = '{8'd192, 8'd192, 8'd0};
            5'd7:  c = '{8'd192, 8'd192, 8'd192};
            5'd8:  c = '{8'd0,   8'd0,   8'd0};
            5'd9:  c = '{8'd96,  8'd96,  8'd255};
            5'd10: c = '{8'd255, 8'd96,  8'd96};
            5'd11: c = '{8'd255, 8'd96,  8'd255};
            5'd12: c = '{8'd96,  8'd255, 8'd96};
            5'd13: c = '{8'd96,  8'd255, 8'd255};
            5'd14: c = '{8'd255, 8'd255, 8'd96};
            5'd15: c = '{8'd255, 8'd255, 8'd255};
            5'd16: c = '{8'd0,   8'd0,   8'd0};
            5'd17: c = '{8'd192, 8'd96,  8'd192};
            5'd18: c = '{8'd192, 8'd0,   8'd96};
            5'd19: c = '{8'd192, 8'd192, 8'd192};
            5'd20: c = '{8'd192, 8'd192, 8'd50};
            5'd21: c = '{8'd192, 8'd192, 8'd192};
            5'd22: c = '{8'd192, 8'd10,  8'd0};
            5'd23: c = '{8'd192, 8'd5,   8'd192};
            5'd24: c = '{8'd0,   8'd0,   8'd0};
            5'd25: c = '{8'd96,  8'd96,  8'd255};
            5'd26: c = '{8'd255, 8'd96,  8'd96};
            5'd27: c = '{8'd255, 8'd96,  8'd255};
            5'd28: c = '{8'd96,  8'd255, 8'd96};
            5'd29: c = '{8'd96,  8'd255, 8'd255};
            5'd30: c = '{8'd60,  8'd255, 8'd96};
            default: c = '{8'd96, 8'd255, 8'd96};
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/core/asc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module asc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/asc_front.sv -----
// Front end: accepts requests, performs memory writes and the two cell reads.
// Depends on asc_pkg and asc_ram; feeds the cell queue.
module asc_front
    import asc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_req_type,
    input  logic [12:0] s_write_addr,
    input  logic [7:0] s_write_data,
    input  logic [7:0] s_row,
    input  logic [4:0] s_column,
    input  logic       s_flash_phase,
    output logic       q_push,
    output asc_cell_t  q_data,
    input  logic       q_ready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ATTR = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [ADDR_W-1:0] attr_addr_reg;
    logic              pix_oob_reg, attr_oob_reg;
    logic [7:0]        pix_reg;
    logic [4:0]        col_reg;
    logic              phase_reg;

    logic              accept;
    logic [12:0]       pix_addr, attr_addr;
    logic [ADDR_W-1:0] raddr;
    logic [7:0]        rdata;
    logic              ram_we;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Interleaved pixel address: row bits 2..0 and 5..3 trade places
    assign pix_addr  = {s_row[7:6], s_row[2:0], s_row[5:3], s_column};
    assign attr_addr = 13'(PIX_BYTES) + {3'b000, s_row[7:3], s_column};

    assign ram_we = accept && (s_req_type == REQ_WRITE)
                    && (s_write_addr < 13'(MEM_BYTES));
    assign raddr  = (state_reg == ST_IDLE) ? ADDR_W'(pix_addr) : attr_addr_reg;

    asc_ram #(
        .WIDTH(8),
        .DEPTH(MEM_BYTES)
    ) u_screen_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ADDR_W'(s_write_addr)),
        .wdata(s_write_data),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_req_type == REQ_RENDER)) begin
                    state_next = ST_ATTR;
                end
            end
            ST_ATTR: state_next = ST_PUSH;
            ST_PUSH: begin
                if (q_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            attr_addr_reg <= ADDR_W'(attr_addr);
            pix_oob_reg   <= (pix_addr >= 13'(MEM_BYTES));
            attr_oob_reg  <= (attr_addr >= 13'(MEM_BYTES));
            col_reg       <= s_column;
            phase_reg     <= s_flash_phase;
        end
        // Pixel byte arrives in the cycle after its read; out-of-range reads give zero
        if (state_reg == ST_ATTR) begin
            pix_reg <= pix_oob_reg ? 8'd0 : rdata;
        end
    end

    // Attribute read address is held through the push state, so rdata stays valid
    assign q_push       = (state_reg == ST_PUSH) && q_ready;
    assign q_data.pix   = pix_reg;
    assign q_data.attr  = attr_oob_reg ? 8'd0 : rdata;
    assign q_data.col   = col_reg;
    assign q_data.phase = phase_reg;

endmodule

// ----- rtl/core/asc_queue.sv -----
// Small FIFO of decoded cell requests between the front and back ends.
// Depends on asc_pkg.
module asc_queue
    import asc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  asc_cell_t push_data,
    output logic      push_ready,
    input  logic      pop,
    output asc_cell_t pop_data,
    output logic      pop_valid
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    asc_cell_t       slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/asc_back.sv -----
// Back end: serializes one cell into eight palette colors through an output register.
// Depends on asc_pkg and the assertion macro header.
`include "attribute_screen_cell_renderer_macros.svh"

module asc_back
    import asc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [4:0] palette_bank,
    input  asc_cell_t  q_data,
    input  logic       q_valid,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_red,
    output logic [7:0] m_green,
    output logic [7:0] m_blue,
    output logic [7:0] m_pixel_x,
    output logic       m_last
);

    asc_cell_t  cell_reg;
    logic       busy_reg;
    logic [2:0] cnt_reg;
    logic       m_valid_reg;
    asc_rgb_t   rgb_reg;
    logic [7:0] pixel_x_reg;
    logic       last_reg;

    logic       adv, done;
    logic [2:0] ink, paper, colour;
    logic       bright, inv, bit_now;
    logic [4:0] pal_idx;
    asc_rgb_t   rgb_now;

    assign adv   = busy_reg && (!m_valid_reg || m_ready);
    assign done  = adv && (cnt_reg == 3'd7);
    assign q_pop = q_valid && (!busy_reg || done);

    assign ink     = cell_reg.attr[2:0] & ATTR_INK_MASK[2:0];
    assign paper   = 3'((cell_reg.attr & ATTR_PAPER_MASK) >> 3);
    assign bright  = |(cell_reg.attr & ATTR_BRIGHT_MASK);
    assign inv     = (|(cell_reg.attr & ATTR_FLASH_MASK)) && cell_reg.phase;
    // Most significant pixel first
    assign bit_now = cell_reg.pix[~cnt_reg];
    assign colour  = (bit_now ^ inv) ? ink : paper;
    assign pal_idx = {2'b00, colour} + {1'b0, bright, 3'b000} + palette_bank;
    assign rgb_now = asc_palette(pal_idx);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            cnt_reg     <= 3'd0;
            m_valid_reg <= 1'b0;
        end else begin
            // A new cell overrides the end of the previous one
            if (q_pop) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd0;
            end else if (adv) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 3'd7) begin
                    busy_reg <= 1'b0;
                end
            end
            if (adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cell_reg <= q_data;
        end
        if (adv) begin
            rgb_reg     <= rgb_now;
            pixel_x_reg <= {cell_reg.col, cnt_reg};
            last_reg    <= (cnt_reg == 3'd7);
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_red     = rgb_reg.red;
    assign m_green   = rgb_reg.green;
    assign m_blue    = rgb_reg.blue;
    assign m_pixel_x = pixel_x_reg;
    assign m_last    = last_reg;

    `ASC_ASSERT_NEXT(a_done_idles, done && !q_valid, !busy_reg)
    `ASC_ASSERT_IMPL(a_mid_cell_busy, m_valid_reg && !last_reg, busy_reg)
    `ASC_ASSERT_IMPL(a_count_tracks_x, m_valid_reg && busy_reg, (pixel_x_reg[2:0] + 3'd1) == cnt_reg)

endmodule

// ----- rtl/core/attribute_screen_cell_renderer.sv -----
// Attribute screen cell renderer. A write request stores one byte of the
// 6912-byte screen memory (pixel bytes then attributes; writes at 6912 or above
// are dropped). A render request reads the cell's pixel byte and attribute
// from the single-read-port screen RAM through the front-end idle, attribute
// and push states, queues the cell, and the back end emits eight pixels, one
// per cycle while m_ready is high, so a stream of renders is paced by the
// pixel serializer. The screen RAM is not cleared at reset; reading a byte
// that was never written gives an unspecified color. palette_bank may be
// written only while the block is idle.
module attribute_screen_cell_renderer
    import asc_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [12:0] s_write_addr,
    input  logic [7:0]  s_write_data,
    input  logic [7:0]  s_row,
    input  logic [4:0]  s_column,
    input  logic        s_flash_phase,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_red,
    output logic [7:0]  m_green,
    output logic [7:0]  m_blue,
    output logic [7:0]  m_pixel_x,
    output logic        m_last
);

    logic [4:0] palette_bank_reg;
    logic       q_push, q_ready, q_pop, q_valid;
    asc_cell_t  q_in, q_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            palette_bank_reg <= 5'd0;
        end else if (cfg_wr_en) begin
            palette_bank_reg <= cfg_wr_data;
        end
    end

    asc_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_write_addr (s_write_addr),
        .s_write_data (s_write_data),
        .s_row        (s_row),
        .s_column     (s_column),
        .s_flash_phase(s_flash_phase),
        .q_push       (q_push),
        .q_data       (q_in),
        .q_ready      (q_ready)
    );

    asc_queue #(
        .DEPTH(QDEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .push_ready(q_ready),
        .pop       (q_pop),
        .pop_data  (q_out),
        .pop_valid (q_valid)
    );

    asc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .palette_bank(palette_bank_reg),
        .q_data      (q_out),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_red       (m_red),
        .m_green     (m_green),
        .m_blue      (m_blue),
        .m_pixel_x   (m_pixel_x),
        .m_last      (m_last)
    );

endmodule
